// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL. They are empty when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define WCR_ASSERT_IMP(lbl, cond, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error("implication check failed");
`define WCR_ASSERT_NEXT(lbl, cond, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error("next-cycle check failed");
`else
`define WCR_ASSERT_IMP(lbl, cond, prop)
`define WCR_ASSERT_NEXT(lbl, cond, prop)
`endif

`endif

// ===== rtl/core/wcr_pkg.sv =====
package wcr_pkg;

   localparam int MAX_COLUMNS_DEFAULT = 4096;
   localparam int LEVEL_BITS_DEFAULT  = 16;

   localparam int BAND_W     = 24;
   localparam int WEIGHT_W   = 28;
   localparam int ROW_W      = 13;
   localparam int INDEX_W    = 12;
   localparam int COLOUR_W   = 8;
   localparam int CSUM_W     = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // Shared divider geometry: every quotient in this block stays below 2**16.
   localparam int DIV_NUM_W = 46;
   localparam int DIV_DEN_W = 29;
   localparam int DIV_Q_W   = 16;

   // Q8.8 colour: 180 * 512 scale and 30.0 offset.
   localparam logic [16:0] Q_SCALE  = 17'd92160;
   localparam logic [15:0] Q_OFFSET = 16'd7680;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BLOCKS  = 2'd0,
      CSR_COLUMNS = 2'd1,
      CSR_HEIGHT  = 2'd2
   } csr_index_type;

   // Divider operation sequence; the order matters, the sequencer steps by one.
   localparam logic [3:0] OP_RED      = 4'd0;
   localparam logic [3:0] OP_GREEN    = 4'd1;
   localparam logic [3:0] OP_BLUE     = 4'd2;
   localparam logic [3:0] OP_ROW_PP   = 4'd3;
   localparam logic [3:0] OP_ROW_RN   = 4'd6;
   localparam logic [3:0] OP_DIM_R    = 4'd7;
   localparam logic [3:0] OP_DIM_B    = 4'd9;
   localparam logic [3:0] OP_BRIGHT_R = 4'd10;
   localparam logic [3:0] OP_LAST     = 4'd12;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] num;
      logic [DIV_DEN_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [DIV_Q_W-1:0] quotient;
   } div_rsp_type;

   function automatic logic [COLOUR_W-1:0] clamp8(input logic [DIV_Q_W-1:0] v);
      return (v > DIV_Q_W'(255)) ? 8'd255 : v[COLOUR_W-1:0];
   endfunction

endpackage

// ===== rtl/core/wcr_req_if.sv =====
interface wcr_req_if #(
   parameter int LEVEL_BITS = wcr_pkg::LEVEL_BITS_DEFAULT
);
   logic                                valid;
   logic                                ready;
   logic signed [LEVEL_BITS-1:0]        peak_positive;
   logic signed [LEVEL_BITS-1:0]        peak_negative;
   logic signed [LEVEL_BITS-1:0]        rms_positive;
   logic signed [LEVEL_BITS-1:0]        rms_negative;
   logic [wcr_pkg::BAND_W-1:0]          band_low_energy;
   logic [wcr_pkg::BAND_W-1:0]          band_mid_energy;
   logic [wcr_pkg::BAND_W-1:0]          band_high_energy;

   modport source (output valid, peak_positive, peak_negative, rms_positive, rms_negative,
                   band_low_energy, band_mid_energy, band_high_energy, input ready);
   modport sink (input valid, peak_positive, peak_negative, rms_positive, rms_negative,
                 band_low_energy, band_mid_energy, band_high_energy, output ready);
endinterface

// ===== rtl/core/wcr_rsp_if.sv =====
interface wcr_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [wcr_pkg::INDEX_W-1:0]   column_index;
   logic [wcr_pkg::ROW_W-1:0]     peak_row_start;
   logic [wcr_pkg::ROW_W-1:0]     peak_row_end;
   logic [wcr_pkg::ROW_W-1:0]     rms_row_start;
   logic [wcr_pkg::ROW_W-1:0]     rms_row_end;
   logic [wcr_pkg::COLOUR_W-1:0]  dim_red;
   logic [wcr_pkg::COLOUR_W-1:0]  dim_green;
   logic [wcr_pkg::COLOUR_W-1:0]  dim_blue;
   logic [wcr_pkg::COLOUR_W-1:0]  bright_red;
   logic [wcr_pkg::COLOUR_W-1:0]  bright_green;
   logic [wcr_pkg::COLOUR_W-1:0]  bright_blue;
   logic                          final_column;

   modport source (output valid, column_index, peak_row_start, peak_row_end, rms_row_start,
                   rms_row_end, dim_red, dim_green, dim_blue, bright_red, bright_green,
                   bright_blue, final_column, input ready);
   modport sink (input valid, column_index, peak_row_start, peak_row_end, rms_row_start,
                 rms_row_end, dim_red, dim_green, dim_blue, bright_red, bright_green,
                 bright_blue, final_column, output ready);
endinterface

// ===== rtl/core/wcr_csr_if.sv =====
interface wcr_csr_if;
   logic                           valid;
   logic                           ready;
   logic [wcr_pkg::CSR_IDX_W-1:0]  index;
   logic [wcr_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/wcr_divider.sv =====
module wcr_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  wcr_pkg::div_req_type div_req,
   output wcr_pkg::div_rsp_type div_rsp
);
   localparam int NW = wcr_pkg::DIV_NUM_W;
   localparam int QW = wcr_pkg::DIV_Q_W;
   localparam int CW = $clog2(QW);

   logic [NW-1:0] rem_ff, rem_in;
   logic [NW-1:0] dsh_ff, dsh_in;
   logic [QW-1:0] q_ff, q_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [NW:0]   trial;

   // Restoring division, one quotient bit per cycle from the top bit down.
   always_comb begin
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {1'b0, rem_ff} - {1'b0, dsh_ff};
      if (div_req.start) begin
         rem_in  = div_req.num;
         dsh_in  = NW'(div_req.den) << (QW - 1);
         q_in    = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[NW]) begin
            rem_in = trial[NW-1:0];
            q_in   = {q_ff[QW-2:0], 1'b1};
         end else begin
            q_in   = {q_ff[QW-2:0], 1'b0};
         end
         dsh_in = dsh_ff >> 1;
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == CW'(QW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      q_ff   <= q_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = q_ff;

endmodule

// ===== rtl/core/waveform_column_renderer_core.sv =====
// Waveform column renderer. Each accepted beat is one analysis block; its three
// band colours are each divided by the band maximum on one shared 16-step
// restoring divider before the next beat is accepted; the divisions are skipped
// when all band energies are zero. The block that closes a column runs ten more
// divisions (four line rows, six colour averages), then holds the column on the
// result channel until it is taken. No new block is accepted while a block is in
// work or a column waits.
// Blocks that arrive after the last column are taken and dropped.
`include "assert_macros.svh"

module waveform_column_renderer_core #(
   parameter int MAX_COLUMNS = wcr_pkg::MAX_COLUMNS_DEFAULT,
   parameter int LEVEL_BITS  = wcr_pkg::LEVEL_BITS_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   wcr_req_if.sink    req_bus,
   wcr_rsp_if.source  rsp_bus,
   wcr_csr_if.sink    csr_bus
);
   localparam int CC_W   = $clog2(MAX_COLUMNS + 1);
   localparam int SUM_W  = LEVEL_BITS + 16;
   localparam int NL_W   = LEVEL_BITS + 18;
   localparam int PROD_W = LEVEL_BITS + 31;
   localparam int NW     = wcr_pkg::DIV_NUM_W;
   localparam int DW     = wcr_pkg::DIV_DEN_W;
   localparam int WW     = wcr_pkg::WEIGHT_W;

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_START = 4'b0010,
      S_WAIT  = 4'b0100,
      S_OUT   = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   logic [15:0]                   bpc_ff, bpc_in;
   logic [12:0]                   ccount_ff, ccount_in;
   logic [12:0]                   height_ff, height_in;
   logic signed [SUM_W-1:0]       lsum_ff [4];
   logic signed [SUM_W-1:0]       lsum_in [4];
   logic [wcr_pkg::CSUM_W-1:0]    csum_ff [3];
   logic [wcr_pkg::CSUM_W-1:0]    csum_in [3];
   logic [WW-1:0]                 w_ff [3];
   logic [WW-1:0]                 w_in [3];
   logic [WW-1:0]                 m_ff, m_in;
   logic [15:0]                   bc_ff, bc_in;
   logic [CC_W-1:0]               col_ff, col_in;
   logic                          fin_ff, fin_in;
   logic                          coldone_ff, coldone_in;
   logic [3:0]                    op_ff, op_in;
   logic [wcr_pkg::ROW_W-1:0]     row_ff [4];
   logic [wcr_pkg::ROW_W-1:0]     row_in [4];
   logic [wcr_pkg::COLOUR_W-1:0]  dim_ff [3];
   logic [wcr_pkg::COLOUR_W-1:0]  dim_in [3];
   logic [wcr_pkg::COLOUR_W-1:0]  bright_ff [3];
   logic [wcr_pkg::COLOUR_W-1:0]  bright_in [3];
   logic [wcr_pkg::INDEX_W-1:0]   idx_ff, idx_in;
   logic                          final_ff, final_in;

   wcr_pkg::div_req_type div_req;
   wcr_pkg::div_rsp_type div_rsp;

   logic [15:0]                   n_blocks;
   logic [31:0]                   cols_wide;
   logic [CC_W-1:0]               cols_lim;
   logic [CC_W:0]                 col_next;
   logic [CC_W+11:0]              col_ext;
   logic [WW-1:0]                 w_new [3];
   logic [WW-1:0]                 m_new;
   logic [16:0]                   bc_next;
   logic                          acc;
   logic [3:0]                    op_off;
   logic signed [NL_W-1:0]        base;
   logic signed [NL_W-1:0]        nl;
   logic [PROD_W-1:0]             prod;
   logic [33:0]                   avg_num;
   logic [wcr_pkg::CSUM_W-1:0]    csum_sel;

   wcr_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign n_blocks  = (bpc_ff == 16'd0) ? 16'd1 : bpc_ff;
   assign cols_wide = (ccount_ff == 13'd0) ? 32'd1 :
                      (32'(ccount_ff) > 32'(MAX_COLUMNS)) ? 32'(MAX_COLUMNS) : 32'(ccount_ff);
   assign cols_lim  = cols_wide[CC_W-1:0];
   assign col_next  = {1'b0, col_ff} + (CC_W + 1)'(1);
   assign col_ext   = {12'd0, col_ff};
   assign bc_next   = {1'b0, bc_ff} + 17'd1;
   assign acc       = req_bus.valid && req_bus.ready;

   assign w_new[0] = WW'(req_bus.band_low_energy);
   assign w_new[1] = WW'({req_bus.band_mid_energy, 1'b0});
   assign w_new[2] = WW'({req_bus.band_high_energy, 3'b000}) +
                     WW'({req_bus.band_high_energy, 1'b0});

   always_comb begin
      m_new = w_new[0];
      if (w_new[1] > m_new) m_new = w_new[1];
      if (w_new[2] > m_new) m_new = w_new[2];
   end

   // Divider operands for the current step of the sequence.
   always_comb begin
      op_off   = '0;
      base     = NL_W'(n_blocks) <<< (LEVEL_BITS - 1);
      nl       = '0;
      prod     = '0;
      avg_num  = '0;
      csum_sel = '0;
      div_req.start = (state_ff == S_START);
      div_req.num   = '0;
      div_req.den   = DW'(n_blocks);
      priority if (op_ff <= wcr_pkg::OP_BLUE) begin
         div_req.num = NW'(w_ff[op_ff[1:0]] * wcr_pkg::Q_SCALE) + NW'(m_ff);
         div_req.den = DW'({m_ff, 1'b0});
      end else if (op_ff <= wcr_pkg::OP_ROW_RN) begin
         op_off = op_ff - wcr_pkg::OP_ROW_PP;
         if (op_off[0])
            nl = base - NL_W'(lsum_ff[op_off[1:0]]);
         else
            nl = base + NL_W'(lsum_ff[op_off[1:0]]);
         // A negative level position puts the row at zero.
         if (nl < 0)
            nl = '0;
         prod = PROD_W'(height_ff) * PROD_W'(nl) +
                (PROD_W'(n_blocks) << (LEVEL_BITS - 1));
         div_req.num = NW'(prod >> LEVEL_BITS);
      end else if (op_ff <= wcr_pkg::OP_DIM_B) begin
         op_off   = op_ff - wcr_pkg::OP_DIM_R;
         csum_sel = csum_ff[op_off[1:0]];
         avg_num  = 34'(csum_sel) + (34'(n_blocks) << 8);
         div_req.num = NW'(avg_num >> 9);
      end else begin
         op_off   = op_ff - wcr_pkg::OP_BRIGHT_R;
         csum_sel = csum_ff[op_off[1:0]];
         avg_num  = {1'b0, csum_sel, 1'b0} + (34'(n_blocks) << 8);
         div_req.num = NW'(avg_num >> 9);
      end
   end

   always_comb begin
      state_in   = state_ff;
      bpc_in     = bpc_ff;
      ccount_in  = ccount_ff;
      height_in  = height_ff;
      lsum_in    = lsum_ff;
      csum_in    = csum_ff;
      w_in       = w_ff;
      m_in       = m_ff;
      bc_in      = bc_ff;
      col_in     = col_ff;
      fin_in     = fin_ff;
      coldone_in = coldone_ff;
      op_in      = op_ff;
      row_in     = row_ff;
      dim_in     = dim_ff;
      bright_in  = bright_ff;
      idx_in     = idx_ff;
      final_in   = final_ff;

      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            wcr_pkg::CSR_BLOCKS:  bpc_in    = csr_bus.data;
            wcr_pkg::CSR_COLUMNS: ccount_in = csr_bus.data[12:0];
            wcr_pkg::CSR_HEIGHT:  height_in = csr_bus.data[12:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (acc && !fin_ff) begin
               lsum_in[0] = lsum_ff[0] + SUM_W'(req_bus.peak_positive);
               lsum_in[1] = lsum_ff[1] + SUM_W'(req_bus.peak_negative);
               lsum_in[2] = lsum_ff[2] + SUM_W'(req_bus.rms_positive);
               lsum_in[3] = lsum_ff[3] + SUM_W'(req_bus.rms_negative);
               w_in       = w_new;
               m_in       = m_new;
               bc_in      = bc_next[15:0];
               coldone_in = (bc_next >= {1'b0, n_blocks});
               // With no band energy the block adds no colour.
               if (m_new != '0) begin
                  op_in    = wcr_pkg::OP_RED;
                  state_in = S_START;
               end else if (bc_next >= {1'b0, n_blocks}) begin
                  op_in    = wcr_pkg::OP_ROW_PP;
                  state_in = S_START;
               end
            end
         end
         S_START: begin
            state_in = S_WAIT;
         end
         S_WAIT: begin
            if (div_rsp.done) begin
               priority if (op_ff <= wcr_pkg::OP_BLUE)
                  csum_in[op_ff[1:0]] = csum_ff[op_ff[1:0]] +
                                        wcr_pkg::CSUM_W'(div_rsp.quotient) +
                                        wcr_pkg::CSUM_W'(wcr_pkg::Q_OFFSET);
               else if (op_ff <= wcr_pkg::OP_ROW_RN)
                  row_in[op_off[1:0]] = div_rsp.quotient[wcr_pkg::ROW_W-1:0];
               else if (op_ff <= wcr_pkg::OP_DIM_B)
                  dim_in[op_off[1:0]] = wcr_pkg::clamp8(div_rsp.quotient);
               else
                  bright_in[op_off[1:0]] = wcr_pkg::clamp8(div_rsp.quotient);

               priority if (op_ff == wcr_pkg::OP_BLUE && !coldone_ff) begin
                  state_in = S_IDLE;
               end else if (op_ff == wcr_pkg::OP_LAST) begin
                  state_in = S_OUT;
                  idx_in   = col_ext[wcr_pkg::INDEX_W-1:0];
                  col_in   = col_next[CC_W-1:0];
                  fin_in   = (col_next >= {1'b0, cols_lim});
                  final_in = (col_next >= {1'b0, cols_lim});
                  bc_in    = '0;
                  for (int i = 0; i < 4; i++) lsum_in[i] = '0;
                  for (int i = 0; i < 3; i++) csum_in[i] = '0;
               end else begin
                  op_in    = op_ff + 4'd1;
                  state_in = S_START;
               end
            end
         end
         S_OUT: begin
            if (rsp_bus.ready)
               state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      w_ff      <= w_in;
      m_ff      <= m_in;
      op_ff     <= op_in;
      row_ff    <= row_in;
      dim_ff    <= dim_in;
      bright_ff <= bright_in;
      idx_ff    <= idx_in;
      final_ff  <= final_in;
      if (reset) begin
         state_ff   <= S_IDLE;
         bpc_ff     <= 16'd1;
         ccount_ff  <= 13'd1;
         height_ff  <= 13'd1;
         for (int i = 0; i < 4; i++) lsum_ff[i] <= '0;
         for (int i = 0; i < 3; i++) csum_ff[i] <= '0;
         bc_ff      <= '0;
         col_ff     <= '0;
         fin_ff     <= 1'b0;
         coldone_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         bpc_ff     <= bpc_in;
         ccount_ff  <= ccount_in;
         height_ff  <= height_in;
         lsum_ff    <= lsum_in;
         csum_ff    <= csum_in;
         bc_ff      <= bc_in;
         col_ff     <= col_in;
         fin_ff     <= fin_in;
         coldone_ff <= coldone_in;
      end
   end

   assign req_bus.ready        = (state_ff == S_IDLE);
   assign csr_bus.ready        = 1'b1;
   assign rsp_bus.valid        = (state_ff == S_OUT);
   assign rsp_bus.column_index = idx_ff;
   assign rsp_bus.peak_row_start = row_ff[0];
   assign rsp_bus.peak_row_end   = row_ff[1];
   assign rsp_bus.rms_row_start  = row_ff[2];
   assign rsp_bus.rms_row_end    = row_ff[3];
   assign rsp_bus.dim_red      = dim_ff[0];
   assign rsp_bus.dim_green    = dim_ff[1];
   assign rsp_bus.dim_blue     = dim_ff[2];
   assign rsp_bus.bright_red   = bright_ff[0];
   assign rsp_bus.bright_green = bright_ff[1];
   assign rsp_bus.bright_blue  = bright_ff[2];
   assign rsp_bus.final_column = final_ff;

   `WCR_ASSERT_IMP(a_rsp_blocks_req, rsp_bus.valid, !req_bus.ready)
   `WCR_ASSERT_NEXT(a_fin_sticky, fin_ff, fin_ff)
   `WCR_ASSERT_IMP(a_done_in_wait, div_rsp.done, state_ff == S_WAIT)
   `WCR_ASSERT_IMP(a_final_sets_fin, rsp_bus.valid && rsp_bus.final_column, fin_ff)

endmodule

// ===== verif/waveform_column_renderer_core_tb.sv =====
module waveform_column_renderer_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam wcr_pkg::csr_index_type CSR_SPARE = wcr_pkg::csr_index_type'(3);
   localparam int SETTLE_CYCLES = 300;
   localparam int STALL_LIMIT = 4000;
   localparam int LEVEL_MAX = 32767;
   localparam int LEVEL_MIN = -32768;

   typedef struct packed {
      logic signed [15:0] peak_pos;
      logic signed [15:0] peak_neg;
      logic signed [15:0] rms_pos;
      logic signed [15:0] rms_neg;
      logic [23:0]        band_lo;
      logic [23:0]        band_mid;
      logic [23:0]        band_hi;
   } block_type;

   typedef struct packed {
      logic [11:0] index;
      logic [12:0] peak_start;
      logic [12:0] peak_stop;
      logic [12:0] rms_start;
      logic [12:0] rms_stop;
      logic [7:0]  dim_r;
      logic [7:0]  dim_g;
      logic [7:0]  dim_b;
      logic [7:0]  bright_r;
      logic [7:0]  bright_g;
      logic [7:0]  bright_b;
      logic        last;
   } column_type;

   typedef struct packed {
      block_type  blk;
      logic       pinned;
      column_type col;
   } stim_row_type;

   localparam column_type NO_COL = '0;

   // Directed rows, run with one block per column and a height of 100.
   // The first five give columns 0..4 whose values are easy to derive.
   localparam int DIRECTED_ROWS = 13;
   localparam stim_row_type directed_rows [0:DIRECTED_ROWS-1] = '{
      '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 24'd0, 24'd0, 24'd0}, 1'b1,
        '{12'd0, 13'd50, 13'd50, 13'd50, 13'd50, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0}},
      '{'{16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767, 24'd1, 24'd0, 24'd0}, 1'b1,
        '{12'd1, 13'd100, 13'd100, 13'd0, 13'd0,
          8'd105, 8'd15, 8'd15, 8'd210, 8'd30, 8'd30, 1'b0}},
      '{'{-16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768, 24'd0, 24'd0, 24'd0}, 1'b1,
        '{12'd2, 13'd0, 13'd0, 13'd100, 13'd100, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0}},
      '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 24'd0, 24'd1, 24'd0}, 1'b1,
        '{12'd3, 13'd50, 13'd50, 13'd50, 13'd50,
          8'd15, 8'd105, 8'd15, 8'd30, 8'd210, 8'd30, 1'b0}},
      '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 24'd0, 24'd0, 24'd1}, 1'b1,
        '{12'd4, 13'd50, 13'd50, 13'd50, 13'd50,
          8'd15, 8'd15, 8'd105, 8'd30, 8'd30, 8'd210, 1'b0}},
      '{'{16'sd1, -16'sd1, 16'sd16384, -16'sd16384, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF},
        1'b0, NO_COL},
      '{'{-16'sd1, 16'sd1, -16'sd16384, 16'sd16384, 24'd5, 24'd0, 24'd1}, 1'b0, NO_COL},
      '{'{16'sd100, 16'sd200, 16'sd300, 16'sd400, 24'hFFFFFF, 24'h800000, 24'd0},
        1'b0, NO_COL},
      '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 24'h123456, 24'h0ABCDE, 24'd1677722},
        1'b0, NO_COL},
      '{'{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 24'd7, 24'd7, 24'd7},
        1'b0, NO_COL},
      '{'{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, 24'd3, 24'd1, 24'd0},
        1'b0, NO_COL},
      '{'{16'sh5555, -16'sh5556, 16'sh2AAA, -16'sh2AAB, 24'h555555, 24'hAAAAAA, 24'h333333},
        1'b0, NO_COL},
      '{'{16'sd12345, -16'sd12345, 16'sd1, 16'sd2, 24'd0, 24'd9, 24'd2}, 1'b0, NO_COL}
   };

   logic clock;
   logic reset;

   wcr_req_if req_bus ();
   wcr_rsp_if rsp_bus ();
   wcr_csr_if csr_bus ();

   waveform_column_renderer_core uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // Predictor copy of the configuration and the accumulation state.
   int unsigned   cfg_blocks;
   int unsigned   cfg_columns;
   int unsigned   cfg_height;
   longint        level_acc [4];
   longint unsigned hue_acc [3];
   int unsigned   blocks_in_column;
   int unsigned   columns_done;
   bit            image_done;

   column_type    pending_columns [$];
   logic          pin_valid;
   column_type    pin_col;
   int            req_idle_pct;
   int            rsp_idle_pct;
   int            errors;
   int unsigned   blocks_taken;
   int unsigned   columns_checked;
   int unsigned   stall_cycles;

   always #5 clock = ~clock;

   function automatic longint unsigned row_value(input longint num, input longint unsigned n,
                                                 input longint unsigned h);
      longint unsigned den;
      longint unsigned r;
      den = n << 16;
      if (num < 0) return 0;
      r = (2 * h * longint'(num) + den) / (2 * den);
      return r & 64'h1FFF;
   endfunction

   function automatic logic [7:0] clamp_colour(input longint unsigned v);
      return (v > 255) ? 8'd255 : v[7:0];
   endfunction

   function automatic bit render_block(input block_type b, output column_type c);
      longint unsigned w [3];
      longint unsigned m;
      longint unsigned n;
      longint unsigned lim;
      longint          base;
      c = '0;
      if (image_done) return 1'b0;
      level_acc[0] += longint'(b.peak_pos);
      level_acc[1] += longint'(b.peak_neg);
      level_acc[2] += longint'(b.rms_pos);
      level_acc[3] += longint'(b.rms_neg);
      w[0] = b.band_lo;
      w[1] = 2 * longint'(b.band_mid);
      w[2] = 10 * longint'(b.band_hi);
      m = w[0];
      if (w[1] > m) m = w[1];
      if (w[2] > m) m = w[2];
      if (m > 0) begin
         for (int i = 0; i < 3; i++) begin
            hue_acc[i] += (w[i] * 92160 + m) / (2 * m) + 7680;
         end
      end
      n = (cfg_blocks == 0) ? 1 : cfg_blocks;
      blocks_in_column++;
      if (blocks_in_column < n) return 1'b0;
      lim = (cfg_columns == 0) ? 1 : cfg_columns;
      if (lim > 4096) lim = 4096;
      base = longint'(n << 15);
      c.index = columns_done[11:0];
      c.peak_start = 13'(row_value(base + level_acc[0], n, cfg_height));
      c.peak_stop  = 13'(row_value(base - level_acc[1], n, cfg_height));
      c.rms_start  = 13'(row_value(base + level_acc[2], n, cfg_height));
      c.rms_stop   = 13'(row_value(base - level_acc[3], n, cfg_height));
      c.dim_r = clamp_colour((hue_acc[0] + n * 256) / (n * 512));
      c.dim_g = clamp_colour((hue_acc[1] + n * 256) / (n * 512));
      c.dim_b = clamp_colour((hue_acc[2] + n * 256) / (n * 512));
      c.bright_r = clamp_colour((2 * hue_acc[0] + n * 256) / (n * 512));
      c.bright_g = clamp_colour((2 * hue_acc[1] + n * 256) / (n * 512));
      c.bright_b = clamp_colour((2 * hue_acc[2] + n * 256) / (n * 512));
      columns_done++;
      if (columns_done >= lim) image_done = 1'b1;
      c.last = image_done;
      blocks_in_column = 0;
      for (int i = 0; i < 4; i++) level_acc[i] = 0;
      for (int i = 0; i < 3; i++) hue_acc[i] = 0;
      return 1'b1;
   endfunction

   task automatic check_field(input string name, input longint unsigned want,
                              input longint unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endtask

   // Predictor updates and result checks, all on values sampled at the edge.
   always @(posedge clock) begin
      block_type  blk;
      column_type col;
      column_type want;
      if (!reset) begin
         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_bus.index)
               wcr_pkg::CSR_BLOCKS:  cfg_blocks = csr_bus.data;
               wcr_pkg::CSR_COLUMNS: cfg_columns = csr_bus.data & 16'h1FFF;
               wcr_pkg::CSR_HEIGHT:  cfg_height = csr_bus.data & 16'h1FFF;
               default: ;
            endcase
         end
         if (req_bus.valid && req_bus.ready) begin
            blk = '{req_bus.peak_positive, req_bus.peak_negative, req_bus.rms_positive,
                    req_bus.rms_negative, req_bus.band_low_energy, req_bus.band_mid_energy,
                    req_bus.band_high_energy};
            blocks_taken++;
            if (render_block(blk, col)) begin
               pending_columns.push_back(pin_valid ? pin_col : col);
            end
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_columns.size() == 0) begin
               $error("column beat with no column expected");
               errors++;
            end else begin
               want = pending_columns.pop_front();
               columns_checked++;
               check_field("column_index", want.index, rsp_bus.column_index);
               check_field("peak_row_start", want.peak_start, rsp_bus.peak_row_start);
               check_field("peak_row_end", want.peak_stop, rsp_bus.peak_row_end);
               check_field("rms_row_start", want.rms_start, rsp_bus.rms_row_start);
               check_field("rms_row_end", want.rms_stop, rsp_bus.rms_row_end);
               check_field("dim_red", want.dim_r, rsp_bus.dim_red);
               check_field("dim_green", want.dim_g, rsp_bus.dim_green);
               check_field("dim_blue", want.dim_b, rsp_bus.dim_blue);
               check_field("bright_red", want.bright_r, rsp_bus.bright_red);
               check_field("bright_green", want.bright_g, rsp_bus.bright_green);
               check_field("bright_blue", want.bright_b, rsp_bus.bright_blue);
               check_field("final_column", want.last, rsp_bus.final_column);
            end
         end
      end
   end

   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_bus.valid && csr_bus.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("Watchdog expired with %0d columns outstanding", pending_columns.size());
         $display("Test completed with failures");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic send_block(input block_type b, input logic pinned, input column_type col);
      req_bus.valid            <= 1'b1;
      req_bus.peak_positive    <= b.peak_pos;
      req_bus.peak_negative    <= b.peak_neg;
      req_bus.rms_positive     <= b.rms_pos;
      req_bus.rms_negative     <= b.rms_neg;
      req_bus.band_low_energy  <= b.band_lo;
      req_bus.band_mid_energy  <= b.band_mid;
      req_bus.band_high_energy <= b.band_hi;
      pin_valid                <= pinned;
      pin_col                  <= col;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      if ($urandom_range(99) < req_idle_pct) begin
         req_bus.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < req_idle_pct);
      end
   endtask

   // Writes every register plus the unused index, which must be ignored.
   task automatic program_regs(input logic [15:0] blocks, input logic [15:0] columns,
                               input logic [15:0] height);
      wcr_pkg::csr_index_type idx [4];
      logic [15:0]            val [4];
      idx = '{wcr_pkg::CSR_BLOCKS, wcr_pkg::CSR_COLUMNS, wcr_pkg::CSR_HEIGHT, CSR_SPARE};
      val = '{blocks, columns, height, 16'h1234};
      for (int i = 0; i < 4; i++) begin
         csr_bus.valid <= 1'b1;
         csr_bus.index <= idx[i];
         csr_bus.data  <= val[i];
         @(posedge clock);
         while (!csr_bus.ready) @(posedge clock);
      end
      csr_bus.valid <= 1'b0;
   endtask

   // A block can be in work with no column due, so drain and then wait it out.
   task automatic settle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_columns.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [15:0] random_level();
      case ($urandom_range(9))
         0: return 16'(LEVEL_MIN);
         1: return 16'(LEVEL_MAX);
         2: return 16'd0;
         3, 4, 5: return ($urandom_range(1) ? 16'($urandom_range(512))
                                           : -16'($urandom_range(512)));
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [23:0] random_band();
      case ($urandom_range(7))
         0: return 24'd0;
         1: return 24'hFFFFFF;
         2: return 24'($urandom_range(15));
         default: return 24'($urandom);
      endcase
   endfunction

   function automatic block_type random_block();
      block_type b;
      b.peak_pos = random_level();
      b.peak_neg = random_level();
      b.rms_pos  = random_level();
      b.rms_neg  = random_level();
      if ($urandom_range(15) == 0) begin
         b.band_lo = '0;
         b.band_mid = '0;
         b.band_hi = '0;
      end else begin
         b.band_lo  = random_band();
         b.band_mid = random_band();
         b.band_hi  = random_band();
      end
      return b;
   endfunction

   initial begin
      logic [15:0] blocks;
      logic [15:0] height;
      clock = 1'b0;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.peak_positive = '0;
      req_bus.peak_negative = '0;
      req_bus.rms_positive = '0;
      req_bus.rms_negative = '0;
      req_bus.band_low_energy = '0;
      req_bus.band_mid_energy = '0;
      req_bus.band_high_energy = '0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = wcr_pkg::CSR_BLOCKS;
      csr_bus.data = '0;
      pin_valid = 1'b0;
      pin_col = '0;
      cfg_blocks = 1;
      cfg_columns = 1;
      cfg_height = 1;
      level_acc = '{0, 0, 0, 0};
      hue_acc = '{0, 0, 0};
      blocks_in_column = 0;
      columns_done = 0;
      image_done = 1'b0;
      errors = 0;
      blocks_taken = 0;
      columns_checked = 0;
      stall_cycles = 0;
      req_idle_pct = 16;
      rsp_idle_pct = 50;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // The all-ones column count is masked to 8191 and capped at the maximum.
      program_regs(16'd1, 16'hFFFF, 16'd100);
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         send_block(directed_rows[i].blk, directed_rows[i].pinned, directed_rows[i].col);
      end
      pin_valid <= 1'b0;
      settle();

      // Start a long column at zero height, then shrink the column length to
      // zero, which counts as one: the next block closes the column.
      program_regs(16'hFFFF, 16'd4096, 16'd0);
      repeat (3) send_block(random_block(), 1'b0, NO_COL);
      settle();
      program_regs(16'd0, 16'd4096, 16'd0);
      send_block(random_block(), 1'b0, NO_COL);
      settle();
      program_regs(16'd1, 16'd4096, 16'hFFFF);
      repeat (6) send_block(random_block(), 1'b0, NO_COL);
      settle();

      for (int phase = 0; phase < 3; phase++) begin
         req_idle_pct = (phase == 0) ? 16 : (phase == 1) ? 50 : 0;
         rsp_idle_pct = (phase == 0) ? 50 : (phase == 1) ? 16 : 0;
         for (int sub = 0; sub < 5; sub++) begin
            case ($urandom_range(5))
               0, 1: blocks = 16'd1;
               2: blocks = 16'd2;
               3: blocks = 16'd3;
               default: blocks = 16'($urandom_range(8, 1));
            endcase
            case ($urandom_range(3))
               0: height = 16'd1;
               1: height = 16'd4096;
               default: height = 16'($urandom_range(4096, 1));
            endcase
            program_regs(blocks, 16'($urandom_range(4096, 4000)), height);
            repeat (75) send_block(random_block(), 1'b0, NO_COL);
            settle();
         end
      end

      // A column count of zero counts as one, so the next column is the last
      // and every block after it is dropped.
      req_idle_pct = 16;
      rsp_idle_pct = 16;
      program_regs(16'd2, 16'd0, 16'd200);
      repeat (10) send_block(random_block(), 1'b0, NO_COL);
      settle();

      $display("Sent %0d analysis blocks and checked %0d image columns", blocks_taken,
               columns_checked);
      $display("Covered level and band extremes, several column lengths and heights,");
      $display("mid-column reconfiguration and blocks dropped after the last column.");
      if (errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/wcr_pkg.sv
rtl/core/wcr_req_if.sv
rtl/core/wcr_rsp_if.sv
rtl/core/wcr_csr_if.sv
rtl/core/wcr_divider.sv
rtl/core/waveform_column_renderer_core.sv
verif/waveform_column_renderer_core_tb.sv
